// ===== hw/rtl/cbc_pkg.sv =====
// Shared types, codes and constants of the cartridge bank controller.
// No dependencies; every other file of the block but cbc_ram refers to it by scoped names.
package cbc_pkg;

  // Field widths of the bus transaction and of its result
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned BANK_W  = 7;

  // Bank register widths
  localparam int unsigned LOW_BANK_W  = 5;
  localparam int unsigned HIGH_BANK_W = 2;
  localparam int unsigned RAM_CNT_W   = 3;

  // Cartridge RAM geometry
  localparam int unsigned MAX_RAM_BANKS  = 4;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned RAM_DEPTH      = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int unsigned RAM_BANK_SEL_W = $clog2(MAX_RAM_BANKS);
  localparam int unsigned RAM_OFFSET_W   = $clog2(RAM_BANK_BYTES);
  localparam int unsigned RAM_ADDR_W     = $clog2(RAM_DEPTH);

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_MULTICART_WIRING = 1'b0;
  localparam logic        REG_RAM_BANK_COUNT   = 1'b1;

  // Key that enables RAM when it appears in the low nibble
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONTROL_WRITE = 2'd0,
    CMD_ROM_QUERY     = 2'd1,
    CMD_RAM_READ      = 2'd2,
    CMD_RAM_WRITE     = 2'd3
  } cmd_e;

  // Control register select, address bits 14..13 of a write below 8000
  typedef enum logic [1:0] {
    CTRL_RAM_ENABLE = 2'd0,
    CTRL_LOW_BANK   = 2'd1,
    CTRL_HIGH_BANK  = 2'd2,
    CTRL_MODE       = 2'd3
  } ctrl_sel_e;

  typedef struct packed {
    logic                 multicart_wiring;
    logic [RAM_CNT_W-1:0] ram_bank_count;
  } cfg_t;

  typedef struct packed {
    logic [BANK_W-1:0]     rom_bank;
    logic                  ram_ok;
    logic [RAM_ADDR_W-1:0] ram_addr;
  } map_t;

endpackage

// ===== hw/rtl/cbc_req_if.sv =====
// Request channel of the cartridge bank controller: one bus transaction.
// Depends on cbc_pkg for field widths.
interface cbc_req_if;
  logic                       valid;
  logic                       ready;
  logic [cbc_pkg::CMD_W-1:0]  command;
  logic [cbc_pkg::ADDR_W-1:0] bus_address;
  logic [cbc_pkg::DATA_W-1:0] write_data;

  modport source (output valid, command, bus_address, write_data, input ready);
  modport sink   (input valid, command, bus_address, write_data, output ready);
endinterface

// ===== hw/rtl/cbc_rsp_if.sv =====
// Response channel of the cartridge bank controller: one result transaction.
// Depends on cbc_pkg for field widths.
interface cbc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cbc_pkg::BANK_W-1:0] rom_bank;
  logic [cbc_pkg::DATA_W-1:0] read_data;
  logic                       read_valid;

  modport source (output valid, rom_bank, read_data, read_valid, input ready);
  modport sink   (input valid, rom_bank, read_data, read_valid, output ready);
endinterface

// ===== hw/rtl/cbc_cfg.sv =====
// APB-style configuration registers: multicart wiring and RAM bank count.
// Depends on cbc_pkg.
module cbc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output cbc_pkg::cfg_t                  cfg_o
);

  cbc_pkg::cfg_t cfg_d, cfg_q;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (reg_sel == cbc_pkg::REG_MULTICART_WIRING) begin
        cfg_d.multicart_wiring = pwdata[0];
      end else begin
        cfg_d.ram_bank_count = pwdata[cbc_pkg::RAM_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    if (reg_sel == cbc_pkg::REG_MULTICART_WIRING) begin
      prdata = {{(cbc_pkg::CFG_DATA_W-1){1'b0}}, cfg_q.multicart_wiring};
    end else begin
      prdata = {{(cbc_pkg::CFG_DATA_W-cbc_pkg::RAM_CNT_W){1'b0}}, cfg_q.ram_bank_count};
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/cbc_bank_regs.sv =====
// Bank control registers and address mapping: ROM bank and RAM byte index.
// Depends on cbc_pkg.
module cbc_bank_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cbc_pkg::cfg_t              cfg_i,
  input  logic                       ctrl_wr_i,
  input  logic [cbc_pkg::ADDR_W-1:0] bus_address_i,
  input  logic [cbc_pkg::DATA_W-1:0] write_data_i,
  output cbc_pkg::map_t              map_o
);

  logic                                ram_enabled_d, ram_enabled_q;
  logic [cbc_pkg::LOW_BANK_W-1:0]      low_bank_d, low_bank_q;
  logic [cbc_pkg::HIGH_BANK_W-1:0]     high_bank_d, high_bank_q;
  logic                                banking_mode_d, banking_mode_q;
  cbc_pkg::ctrl_sel_e                  ctrl_sel;

  logic [cbc_pkg::LOW_BANK_W-1:0]      low_eff;
  logic [cbc_pkg::BANK_W-1:0]          upper;
  logic [cbc_pkg::BANK_W-1:0]          low_ext;
  logic [cbc_pkg::RAM_CNT_W-1:0]       bank_mask;
  logic [cbc_pkg::RAM_CNT_W-1:0]       ram_bank_raw;
  logic [cbc_pkg::RAM_BANK_SEL_W-1:0]  ram_bank;

  assign ctrl_sel = cbc_pkg::ctrl_sel_e'(bus_address_i[14:13]);

  // Control writes at 8000 and above fall off the register map
  always_comb begin
    ram_enabled_d  = ram_enabled_q;
    low_bank_d     = low_bank_q;
    high_bank_d    = high_bank_q;
    banking_mode_d = banking_mode_q;
    if (ctrl_wr_i && !bus_address_i[15]) begin
      case (ctrl_sel)
        cbc_pkg::CTRL_RAM_ENABLE: ram_enabled_d = (write_data_i[3:0] == cbc_pkg::RAM_ENABLE_KEY);
        cbc_pkg::CTRL_LOW_BANK:   low_bank_d    = write_data_i[cbc_pkg::LOW_BANK_W-1:0];
        cbc_pkg::CTRL_HIGH_BANK:  high_bank_d   = write_data_i[cbc_pkg::HIGH_BANK_W-1:0];
        cbc_pkg::CTRL_MODE:       banking_mode_d = write_data_i[0];
        default:                  ram_enabled_d = ram_enabled_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_enabled_q  <= 1'b0;
      low_bank_q     <= '0;
      high_bank_q    <= '0;
      banking_mode_q <= 1'b0;
    end else begin
      ram_enabled_q  <= ram_enabled_d;
      low_bank_q     <= low_bank_d;
      high_bank_q    <= high_bank_d;
      banking_mode_q <= banking_mode_d;
    end
  end

  // Substitute bank 1 for bank 0, then drop bit 4 in multicart wiring
  always_comb begin
    low_eff = (low_bank_q == '0) ? cbc_pkg::LOW_BANK_W'(1) : low_bank_q;
    if (cfg_i.multicart_wiring) begin
      low_eff[cbc_pkg::LOW_BANK_W-1] = 1'b0;
      upper = {1'b0, high_bank_q, 4'b0000};
    end else begin
      upper = {high_bank_q, 5'b00000};
    end
    low_ext = {2'b00, low_eff};
  end

  always_comb begin
    if (bus_address_i[15:14] == 2'b00) begin
      map_o.rom_bank = banking_mode_q ? upper : '0;
    end else begin
      map_o.rom_bank = upper | low_ext;
    end
  end

  // RAM bank in mode 1: high bank masked by count - 1, wrapped to the banks present; bank 0 in mode 0
  assign bank_mask    = cfg_i.ram_bank_count - cbc_pkg::RAM_CNT_W'(1);
  assign ram_bank_raw = {{(cbc_pkg::RAM_CNT_W-cbc_pkg::HIGH_BANK_W){1'b0}}, high_bank_q} & bank_mask;
  assign ram_bank     = banking_mode_q ? ram_bank_raw[cbc_pkg::RAM_BANK_SEL_W-1:0] : '0;

  assign map_o.ram_ok   = ram_enabled_q && (cfg_i.ram_bank_count != '0);
  assign map_o.ram_addr = {ram_bank, bus_address_i[cbc_pkg::RAM_OFFSET_W-1:0]};

endmodule

// ===== hw/rtl/cbc_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Stand-alone; the read data holds until the next read.
module cbc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cartridge_bank_controller_unit.sv =====
// Cartridge bank controller (MBC1-style mapper). Each request transaction is one
// bus access: a control write, a ROM bank query, a RAM read or a RAM write; each
// one yields exactly one response transaction. The block takes one transaction
// per cycle while the response side keeps up. A transaction passes stage 1, where
// the single cartridge RAM port's registered read data lands in the cycle after
// the access, then the output register. Bank registers are updated at acceptance,
// so the next transaction already sees a control write. Cartridge RAM (32 KiB) is
// not cleared at reset and reads of unwritten bytes are undefined. The user must
// write configuration (multicart wiring at 0x0, RAM bank count at 0x4) over the
// APB-style port only while the block is idle; the block does not enforce this.
module cartridge_bank_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cbc_req_if.sink                        req_i,
  cbc_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  cbc_pkg::cfg_t  cfg;
  cbc_pkg::map_t  map;
  cbc_pkg::cmd_e  cmd;

  logic                         in_fire;
  logic                         ram_en;
  logic                         ram_we;
  logic [cbc_pkg::DATA_W-1:0]   ram_rdata;

  // Stage 1: transaction accepted, RAM access in flight
  logic                         s1_valid_d, s1_valid_q;
  logic [cbc_pkg::BANK_W-1:0]   s1_rom_bank_q;
  logic                         s1_served_q;
  logic                         s1_adv;

  // Output register
  logic                         o_valid_d, o_valid_q;
  logic [cbc_pkg::BANK_W-1:0]   o_rom_bank_q;
  logic [cbc_pkg::DATA_W-1:0]   o_read_data_q;
  logic                         o_read_valid_q;

  assign cmd = cbc_pkg::cmd_e'(req_i.command);

  cbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbc_bank_regs u_bank_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .ctrl_wr_i     (in_fire && (cmd == cbc_pkg::CMD_CONTROL_WRITE)),
    .bus_address_i (req_i.bus_address),
    .write_data_i  (req_i.write_data),
    .map_o         (map)
  );

  // Advance stage 1 whenever the output register is empty or being drained;
  // accept a new transaction whenever stage 1 is empty or frees up in the same cycle.
  assign s1_adv      = s1_valid_q && (!o_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = req_i.valid && req_i.ready;

  // Drive the RAM port at acceptance; drop accesses while RAM is unreachable
  assign ram_en = in_fire && map.ram_ok &&
                  ((cmd == cbc_pkg::CMD_RAM_READ) || (cmd == cbc_pkg::CMD_RAM_WRITE));
  assign ram_we = (cmd == cbc_pkg::CMD_RAM_WRITE);

  cbc_ram #(
    .DEPTH (cbc_pkg::RAM_DEPTH),
    .WIDTH (cbc_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (map.ram_addr),
    .wdata_i (req_i.write_data),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    if (s1_adv) begin
      o_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  // Capture the result fields known at acceptance
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_rom_bank_q <= (cmd == cbc_pkg::CMD_ROM_QUERY) ? map.rom_bank : '0;
      s1_served_q   <= (cmd == cbc_pkg::CMD_RAM_READ) && map.ram_ok;
    end
  end

  // Merge RAM read data into the result on its way to the output register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      o_rom_bank_q   <= s1_rom_bank_q;
      o_read_data_q  <= s1_served_q ? ram_rdata : '0;
      o_read_valid_q <= s1_served_q;
    end
  end

  assign rsp_o.valid      = o_valid_q;
  assign rsp_o.rom_bank   = o_rom_bank_q;
  assign rsp_o.read_data  = o_read_data_q;
  assign rsp_o.read_valid = o_read_valid_q;

`ifndef SYNTHESIS
  // An accepted transaction always lands in stage 1
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted transaction did not reach stage 1");

  // A blocked stage 1 keeps its RAM read data
  a_s1_hold_rdata : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(ram_rdata)))
    else $error("stage 1 lost its RAM read data while stalled");

  // Backpressure only when both stages are full
  a_ready_low_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && o_valid_q))
    else $error("request stalled with a free stage");

  // A served read never carries a ROM bank
  a_read_no_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_read_valid_q) |-> (o_rom_bank_q == '0))
    else $error("served RAM read carries a ROM bank");
`endif

endmodule

// ===== verif/cbc_reply_checker.sv =====
// Response checker for the cartridge bank controller: watches request, response and config port.
// Keeps its own copy of the bank registers and cartridge RAM; depends on cbc_pkg and the channel
// interfaces.
`timescale 1ns / 100ps

module cbc_reply_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cbc_req_if                             req,
  cbc_rsp_if                             rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatch_count_o,
  output int                             pending_o,
  output int                             replies_seen_o
);

  localparam logic [cbc_pkg::CFG_ADDR_W-1:0] MW_ADDR  =
    cbc_pkg::CFG_ADDR_W'({cbc_pkg::REG_MULTICART_WIRING, 2'b00});
  localparam logic [cbc_pkg::CFG_ADDR_W-1:0] CNT_ADDR =
    cbc_pkg::CFG_ADDR_W'({cbc_pkg::REG_RAM_BANK_COUNT, 2'b00});
  localparam logic [cbc_pkg::ADDR_W-1:0]     ROM_SWITCH_BASE = 16'h4000;
  localparam logic [cbc_pkg::BANK_W-1:0]     MC_LOW_MASK     = 7'h0F;
  localparam int                             MC_HIGH_SHIFT   = 4;
  localparam int                             STD_HIGH_SHIFT  = 5;
  localparam int                             REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [cbc_pkg::BANK_W-1:0] rom_bank;
    logic [cbc_pkg::DATA_W-1:0] read_data;
    logic                       read_valid;
  } bus_reply_t;

  logic                            cur_multi;
  logic [cbc_pkg::RAM_CNT_W-1:0]   cur_count;
  logic                            cur_ram_on;
  logic [cbc_pkg::LOW_BANK_W-1:0]  cur_low;
  logic [cbc_pkg::HIGH_BANK_W-1:0] cur_high;
  logic                            cur_mode;
  logic [cbc_pkg::DATA_W-1:0]      ram_image [cbc_pkg::RAM_DEPTH];

  bus_reply_t replies_due [$];
  bus_reply_t got;
  bus_reply_t want;

  function automatic logic [cbc_pkg::BANK_W-1:0] mapped_rom_bank(
    input logic [cbc_pkg::ADDR_W-1:0] addr);
    logic [cbc_pkg::BANK_W-1:0] low;
    logic [cbc_pkg::BANK_W-1:0] upper;
    low   = (cur_low == '0) ? cbc_pkg::BANK_W'(1) : cbc_pkg::BANK_W'(cur_low);
    upper = cbc_pkg::BANK_W'(cur_high) << (cur_multi ? MC_HIGH_SHIFT : STD_HIGH_SHIFT);
    // multicart drops bit 4 only after the zero-to-one substitution
    if (cur_multi) low = low & MC_LOW_MASK;
    if (addr < ROM_SWITCH_BASE) return cur_mode ? upper : '0;
    return upper | low;
  endfunction

  function automatic int ram_slot(input logic [cbc_pkg::ADDR_W-1:0] addr);
    int bank;
    bank = cur_mode ? ((int'(cur_high) & (int'(cur_count) - 1)) % cbc_pkg::MAX_RAM_BANKS) : 0;
    return bank * cbc_pkg::RAM_BANK_BYTES + int'(addr[cbc_pkg::RAM_OFFSET_W-1:0]);
  endfunction

  // Apply one bus access to the local state and return the reply it must produce
  function automatic bus_reply_t serve_access(input cbc_pkg::cmd_e cmd,
                                              input logic [cbc_pkg::ADDR_W-1:0] addr,
                                              input logic [cbc_pkg::DATA_W-1:0] data);
    bus_reply_t r;
    logic       ram_live;
    r        = '0;
    ram_live = cur_ram_on && (cur_count != '0);
    case (cmd)
      cbc_pkg::CMD_CONTROL_WRITE: begin
        if (!addr[cbc_pkg::ADDR_W-1]) begin
          case (cbc_pkg::ctrl_sel_e'(addr[14:13]))
            cbc_pkg::CTRL_RAM_ENABLE: cur_ram_on = (data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
            cbc_pkg::CTRL_LOW_BANK:   cur_low    = data[cbc_pkg::LOW_BANK_W-1:0];
            cbc_pkg::CTRL_HIGH_BANK:  cur_high   = data[cbc_pkg::HIGH_BANK_W-1:0];
            cbc_pkg::CTRL_MODE:       cur_mode   = data[0];
            default: ;
          endcase
        end
      end
      cbc_pkg::CMD_ROM_QUERY: r.rom_bank = mapped_rom_bank(addr);
      cbc_pkg::CMD_RAM_READ: begin
        if (ram_live) begin
          r.read_data  = ram_image[ram_slot(addr)];
          r.read_valid = 1'b1;
        end
      end
      cbc_pkg::CMD_RAM_WRITE: begin
        if (ram_live) ram_image[ram_slot(addr)] = data;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_multi        = 1'b0;
      cur_count        = '0;
      cur_ram_on       = 1'b0;
      cur_low          = '0;
      cur_high         = '0;
      cur_mode         = 1'b0;
      replies_due.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      replies_seen_o   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == MW_ADDR) cur_multi = pwdata[0];
        else if (paddr == CNT_ADDR) cur_count = pwdata[cbc_pkg::RAM_CNT_W-1:0];
      end
      // queue the prediction first so a same-edge reply still finds its entry
      if (req.valid && req.ready)
        replies_due.push_back(serve_access(cbc_pkg::cmd_e'(req.command), req.bus_address,
                                           req.write_data));
      if (rsp.valid && rsp.ready) begin
        got = '{rom_bank: rsp.rom_bank, read_data: rsp.read_data, read_valid: rsp.read_valid};
        replies_seen_o++;
        if (replies_due.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("[%0t] unexpected reply: rom_bank=%0h read_data=%0h read_valid=%0b",
                     $realtime, got.rom_bank, got.read_data, got.read_valid);
          mismatch_count_o++;
        end else begin
          want = replies_due.pop_front();
          if (got.rom_bank !== want.rom_bank || got.read_data !== want.read_data ||
              got.read_valid !== want.read_valid) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("[%0t] reply mismatch: expected rom_bank=%0h read_data=%0h valid=%0b,%s",
                       $realtime, want.rom_bank, want.read_data, want.read_valid,
                       $sformatf(" got rom_bank=%0h read_data=%0h valid=%0b",
                                 got.rom_bank, got.read_data, got.read_valid));
            mismatch_count_o++;
          end
        end
      end
      pending_o = replies_due.size();
    end
  end

endmodule

// ===== verif/cartridge_bank_controller_unit_test.sv =====
// Testbench top for the cartridge bank controller: drives bus transactions and config writes.
// Instantiates the block and cbc_reply_checker; depends on cbc_pkg and the channel interfaces.
`timescale 1ns / 100ps

module cartridge_bank_controller_unit_test;

  localparam int                             CYCLE_LIMIT  = 1000000;
  localparam int                             PHASES       = 10;
  localparam int                             PHASE_ITEMS  = 175;
  localparam int                             HOLD_CYCLES  = 150;
  localparam int                             HOLD_AFTER   = 700;
  localparam int                             DRAIN_CYCLES = 8;
  localparam logic [cbc_pkg::CFG_ADDR_W-1:0] MW_ADDR  =
    cbc_pkg::CFG_ADDR_W'({cbc_pkg::REG_MULTICART_WIRING, 2'b00});
  localparam logic [cbc_pkg::CFG_ADDR_W-1:0] CNT_ADDR =
    cbc_pkg::CFG_ADDR_W'({cbc_pkg::REG_RAM_BANK_COUNT, 2'b00});
  // A15..A13 of the cartridge RAM window A000-BFFF
  localparam logic [2:0]                     RAM_WINDOW = 3'b101;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [cbc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [cbc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  int mismatch_count;
  int pending;
  int replies_seen;
  int cycle_count;
  int items_sent;
  int settings_done;
  bit hold_rsp;
  bit hold_done;
  bit send_idle;
  bit recv_idle;

  // Stimulus-side view of the mapper, used only to aim RAM reads at bytes already written
  logic                             sh_multi;
  logic [cbc_pkg::RAM_CNT_W-1:0]    sh_count;
  logic                             sh_ram_on;
  logic [cbc_pkg::HIGH_BANK_W-1:0]  sh_high;
  logic                             sh_mode;
  bit                               written_map [cbc_pkg::RAM_DEPTH];
  logic [cbc_pkg::RAM_OFFSET_W-1:0] bank_offsets [cbc_pkg::MAX_RAM_BANKS][$];

  int plan_count [PHASES] = '{4, 0, 1, 2, 3, 7, 5, 6, 0, 4};

  cbc_req_if req_ch ();
  cbc_rsp_if rsp_ch ();

  cartridge_bank_controller_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cbc_reply_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .replies_seen_o   (replies_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count++;

  // Abort a hung run: the limit is far above the slowest legal run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d replies outstanding", cycle_count, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Response side: random stalls, plus the long hold-off when requested
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (recv_idle) stall_left = pause_len();
      end
    end
  end

  // Hold the response side for a long stretch mid-run so the block backs up into its input
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk_i);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp  = 1'b0;
    hold_done = 1'b1;
  end

  function automatic bit ram_live();
    return sh_ram_on && (sh_count != '0);
  endfunction

  function automatic int live_bank();
    return sh_mode ? ((int'(sh_high) & (int'(sh_count) - 1)) % cbc_pkg::MAX_RAM_BANKS) : 0;
  endfunction

  // Drop the request first so the last transaction is not offered again
  task automatic wait_drained();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Two-phase APB write; only called with the block idle
  task automatic write_reg(input logic [cbc_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [cbc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == MW_ADDR) sh_multi = val[0];
    else if (addr == CNT_ADDR) sh_count = val[cbc_pkg::RAM_CNT_W-1:0];
  endtask

  task automatic apply_setting(input logic mw, input logic [cbc_pkg::RAM_CNT_W-1:0] cnt);
    wait_drained();
    repeat (4) @(negedge clk_i);
    write_reg(MW_ADDR, cbc_pkg::CFG_DATA_W'(mw));
    write_reg(CNT_ADDR, cbc_pkg::CFG_DATA_W'(cnt));
    settings_done++;
  endtask

  task automatic idle_gap();
    int n;
    n = send_idle ? pause_len() : 0;
    repeat (n) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
  endtask

  // Offer one bus transaction and hold it until accepted. A RAM read that would land on a byte
  // never written is redirected to a written byte of the same bank, or becomes a write.
  task automatic issue(input cbc_pkg::cmd_e cmd, input logic [cbc_pkg::ADDR_W-1:0] addr,
                       input logic [cbc_pkg::DATA_W-1:0] data);
    cbc_pkg::cmd_e c;
    int            bank;
    int            slot;
    int            pick;
    c = cmd;
    if (c == cbc_pkg::CMD_RAM_READ && ram_live()) begin
      bank = live_bank();
      slot = bank * cbc_pkg::RAM_BANK_BYTES + int'(addr[cbc_pkg::RAM_OFFSET_W-1:0]);
      if (!written_map[slot]) begin
        if (bank_offsets[bank].size() > 0) begin
          pick = $urandom_range(0, bank_offsets[bank].size() - 1);
          addr[cbc_pkg::RAM_OFFSET_W-1:0] = bank_offsets[bank][pick];
        end else begin
          c = cbc_pkg::CMD_RAM_WRITE;
        end
      end
    end
    idle_gap();
    @(negedge clk_i);
    req_ch.valid       <= 1'b1;
    req_ch.command     <= c;
    req_ch.bus_address <= addr;
    req_ch.write_data  <= data;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
    // advance the stimulus-side view to match what the block now holds
    case (c)
      cbc_pkg::CMD_CONTROL_WRITE: begin
        if (!addr[cbc_pkg::ADDR_W-1]) begin
          case (cbc_pkg::ctrl_sel_e'(addr[14:13]))
            cbc_pkg::CTRL_RAM_ENABLE: sh_ram_on = (data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
            cbc_pkg::CTRL_HIGH_BANK:  sh_high   = data[cbc_pkg::HIGH_BANK_W-1:0];
            cbc_pkg::CTRL_MODE:       sh_mode   = data[0];
            default: ;
          endcase
        end
      end
      cbc_pkg::CMD_RAM_WRITE: begin
        if (ram_live()) begin
          bank = live_bank();
          slot = bank * cbc_pkg::RAM_BANK_BYTES + int'(addr[cbc_pkg::RAM_OFFSET_W-1:0]);
          if (!written_map[slot]) begin
            written_map[slot] = 1'b1;
            bank_offsets[bank].push_back(addr[cbc_pkg::RAM_OFFSET_W-1:0]);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [cbc_pkg::ADDR_W-1:0] ctrl_addr(input cbc_pkg::ctrl_sel_e sel);
    logic [cbc_pkg::ADDR_W-1:0] a;
    a = $urandom;
    return {1'b0, sel, a[12:0]};
  endfunction

  // One random transaction: mostly well-aimed control and RAM traffic, some ignored noise
  task automatic random_item();
    int                         r;
    int                         bank;
    logic [cbc_pkg::ADDR_W-1:0] addr;
    logic [cbc_pkg::DATA_W-1:0] data;
    cbc_pkg::ctrl_sel_e         sel;
    r    = $urandom_range(0, 99);
    addr = $urandom;
    data = $urandom;
    if (r < 22) begin
      sel  = cbc_pkg::ctrl_sel_e'($urandom_range(0, 3));
      addr = ctrl_addr(sel);
      // lean toward the unlock key so RAM stays reachable most of the time
      if (sel == cbc_pkg::CTRL_RAM_ENABLE && $urandom_range(0, 3) != 0)
        data[3:0] = cbc_pkg::RAM_ENABLE_KEY;
      issue(cbc_pkg::CMD_CONTROL_WRITE, addr, data);
    end else if (r < 26) begin
      addr[cbc_pkg::ADDR_W-1] = 1'b1;
      issue(cbc_pkg::CMD_CONTROL_WRITE, addr, data);
    end else if (r < 48) begin
      issue(cbc_pkg::CMD_ROM_QUERY, addr, data);
    end else if (r < 74) begin
      if ($urandom_range(0, 4) != 0) addr[15:13] = RAM_WINDOW;
      issue(cbc_pkg::CMD_RAM_READ, addr, data);
    end else begin
      if ($urandom_range(0, 4) != 0) addr[15:13] = RAM_WINDOW;
      if (ram_live() && $urandom_range(0, 1) == 1) begin
        bank = live_bank();
        if (bank_offsets[bank].size() > 0)
          addr[cbc_pkg::RAM_OFFSET_W-1:0] =
            bank_offsets[bank][$urandom_range(0, bank_offsets[bank].size() - 1)];
      end
      issue(cbc_pkg::CMD_RAM_WRITE, addr, data);
    end
  endtask

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.command     <= cbc_pkg::CMD_CONTROL_WRITE;
    req_ch.bus_address <= '0;
    req_ch.write_data  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    sh_multi  = 1'b0;
    sh_count  = '0;
    sh_ram_on = 1'b0;
    sh_high   = '0;
    sh_mode   = 1'b0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: register extremes, each command, address edges
    apply_setting(1'b0, 3'd4);
    issue(cbc_pkg::CMD_ROM_QUERY, 16'h0000, 8'h00);     // mode 0 low half reads bank 0
    issue(cbc_pkg::CMD_RAM_READ, 16'hA000, 8'h00);      // RAM still locked
    issue(cbc_pkg::CMD_RAM_WRITE, 16'hA000, 8'h55);     // dropped while locked
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_RAM_ENABLE), 8'h0A);
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_LOW_BANK), 8'h00);
    issue(cbc_pkg::CMD_ROM_QUERY, 16'h7FFF, 8'h00);     // low bank zero reads as one
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_LOW_BANK), 8'hFF);
    issue(cbc_pkg::CMD_ROM_QUERY, 16'h4000, 8'h00);
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_HIGH_BANK), 8'hFF);
    issue(cbc_pkg::CMD_ROM_QUERY, 16'hFFFF, 8'h00);     // above 8000 answers like 4000-7FFF
    issue(cbc_pkg::CMD_ROM_QUERY, 16'h3FFF, 8'h00);
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_MODE), 8'h01);
    issue(cbc_pkg::CMD_ROM_QUERY, 16'h0000, 8'h00);     // mode 1 maps high bank into low half
    issue(cbc_pkg::CMD_RAM_WRITE, 16'hBFFF, 8'hFF);
    issue(cbc_pkg::CMD_RAM_READ, 16'hBFFF, 8'h00);
    issue(cbc_pkg::CMD_RAM_WRITE, 16'h1FFF, 8'h00);     // outside the window, same byte
    issue(cbc_pkg::CMD_RAM_READ, 16'hBFFF, 8'h00);
    issue(cbc_pkg::CMD_CONTROL_WRITE, 16'h8000, 8'h00); // ignored control write
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_RAM_ENABLE), 8'hFB);
    issue(cbc_pkg::CMD_RAM_READ, 16'hA000, 8'h00);
    issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_MODE), 8'hFE);

    for (int phase = 0; phase < PHASES; phase++) begin
      apply_setting(phase % 2 == 0, cbc_pkg::RAM_CNT_W'(plan_count[phase]));
      // alternate calm stretches with idling on one or both sides
      send_idle = (phase % 4 == 1) || (phase % 4 == 2);
      recv_idle = (phase % 4 == 1) || (phase % 4 == 3);
      if (phase == 0) begin
        // multicart: low bank 0x10 is not zero, so it contributes nothing
        issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_LOW_BANK), 8'h10);
        issue(cbc_pkg::CMD_ROM_QUERY, 16'h4000, 8'h00);
        issue(cbc_pkg::CMD_CONTROL_WRITE, ctrl_addr(cbc_pkg::CTRL_LOW_BANK), 8'h00);
        issue(cbc_pkg::CMD_ROM_QUERY, 16'h7000, 8'h00);
      end
      repeat (PHASE_ITEMS) random_item();
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bus transactions over %0d config settings, checked %0d replies,",
             items_sent, settings_done, replies_seen);
    $display("long response hold-off %0s, %0d cycles", hold_done ? "done" : "missed",
             cycle_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, replies still outstanding: %0d", mismatch_count, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== cartridge_bank_controller_unit.f =====
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_req_if.sv
hw/rtl/cbc_rsp_if.sv
hw/rtl/cbc_cfg.sv
hw/rtl/cbc_bank_regs.sv
hw/rtl/cbc_ram.sv
hw/rtl/cartridge_bank_controller_unit.sv
verif/cbc_reply_checker.sv
verif/cartridge_bank_controller_unit_test.sv
